### rtl/core/sorted_timeout_queue_defines.svh
// Assertion macros shared by the sorted timeout queue.
`ifndef SORTED_TIMEOUT_QUEUE_DEFINES_SVH
`define SORTED_TIMEOUT_QUEUE_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define STQ_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("sorted_timeout_queue: invariant violated");

// When the trigger holds, the consequence holds at the next clock edge.
`define STQ_ASSERT_NEXT(lbl, trig, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("sorted_timeout_queue: sequence violated");

`endif

### rtl/core/stq_pkg.sv
package stq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int TIME_BITS    = 32;
   localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int ID_BITS      = 8;
   localparam int PENDING_BITS = 5;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_POLL   = 1'b1;

   typedef struct packed {
      logic               func;
      logic [ID_BITS-1:0] task_id;
      logic [31:0]        sleep_ticks;
      logic [31:0]        now_ticks;
   } req_type;

   typedef struct packed {
      logic                    woke;
      logic [ID_BITS-1:0]      woken_task;
      logic                    dropped_full;
      logic [PENDING_BITS-1:0] pending;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

### rtl/core/stq_ctrl.sv
module stq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::sts_type sts,
   output stq_pkg::cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   // No transfer is taken while reset is held.
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/stq_datapath.sv
module stq_datapath (
   input  logic             clock,
   input  logic             reset,
   input  stq_pkg::req_type req_data,
   input  stq_pkg::cmd_type cmd,
   output stq_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data
);

   logic                              func_ff;
   logic [stq_pkg::ID_BITS-1:0]       id_ff;
   logic [stq_pkg::TIME_BITS-1:0]     wake_ff;
   logic [stq_pkg::TIME_BITS-1:0]     now_ff;
   logic [stq_pkg::TIME_BITS-1:0]     times_ff [stq_pkg::QUEUE_DEPTH];
   logic [stq_pkg::TIME_BITS-1:0]     times_in [stq_pkg::QUEUE_DEPTH];
   logic [stq_pkg::ID_BITS-1:0]       ids_ff   [stq_pkg::QUEUE_DEPTH];
   logic [stq_pkg::ID_BITS-1:0]       ids_in   [stq_pkg::QUEUE_DEPTH];
   logic [stq_pkg::TIME_BITS-1:0]     prev_time [stq_pkg::QUEUE_DEPTH];
   logic [stq_pkg::ID_BITS-1:0]       prev_id   [stq_pkg::QUEUE_DEPTH];
   logic [stq_pkg::TIME_BITS-1:0]     next_time [stq_pkg::QUEUE_DEPTH];
   logic [stq_pkg::ID_BITS-1:0]       next_id   [stq_pkg::QUEUE_DEPTH];
   logic [stq_pkg::QUEUE_DEPTH-1:0]   le;
   logic [stq_pkg::QUEUE_DEPTH-1:0]   le_prev;
   logic [stq_pkg::COUNT_BITS-1:0]    count_ff;
   logic [stq_pkg::COUNT_BITS-1:0]    count_in;
   logic                              full;
   logic                              expired;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   stq_pkg::rsp_type                  rsp_ff;
   stq_pkg::rsp_type                  rsp_in;

   assign full    = (count_ff == stq_pkg::COUNT_BITS'(stq_pkg::QUEUE_DEPTH));
   assign expired = (count_ff != '0) && (now_ff >= times_ff[0]);

   // Entries at or below the new wake time form a prefix, since the queue is sorted.
   for (genvar k = 0; k < stq_pkg::QUEUE_DEPTH; k++) begin : g_cell
      assign le[k] = (stq_pkg::COUNT_BITS'(k) < count_ff) && (times_ff[k] <= wake_ff);
      if (k == 0) begin : g_first
         assign le_prev[k]   = 1'b1;
         assign prev_time[k] = wake_ff;
         assign prev_id[k]   = id_ff;
      end else begin : g_rest
         assign le_prev[k]   = le[k-1];
         assign prev_time[k] = times_ff[k-1];
         assign prev_id[k]   = ids_ff[k-1];
      end
      if (k == stq_pkg::QUEUE_DEPTH - 1) begin : g_last
         assign next_time[k] = times_ff[k];
         assign next_id[k]   = ids_ff[k];
      end else begin : g_inner
         assign next_time[k] = times_ff[k+1];
         assign next_id[k]   = ids_ff[k+1];
      end
   end

   always_comb begin
      times_in     = times_ff;
      ids_in       = ids_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.exec) begin
         rsp_in       = '0;
         rsp_valid_in = 1'b1;
         if (func_ff == stq_pkg::FUNC_INSERT) begin
            if (full) begin
               rsp_in.dropped_full = 1'b1;
            end else begin
               for (int k = 0; k < stq_pkg::QUEUE_DEPTH; k++) begin
                  if (le[k]) begin
                     times_in[k] = times_ff[k];
                     ids_in[k]   = ids_ff[k];
                  end else if (le_prev[k]) begin
                     times_in[k] = wake_ff;
                     ids_in[k]   = id_ff;
                  end else begin
                     times_in[k] = prev_time[k];
                     ids_in[k]   = prev_id[k];
                  end
               end
               count_in = count_ff + 1'b1;
            end
         end else if (expired) begin
            rsp_in.woke       = 1'b1;
            rsp_in.woken_task = ids_ff[0];
            times_in          = next_time;
            ids_in            = next_id;
            count_in          = count_ff - 1'b1;
         end
         rsp_in.pending = stq_pkg::PENDING_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_data.func;
         id_ff   <= req_data.task_id;
         now_ff  <= stq_pkg::TIME_BITS'(req_data.now_ticks);
         wake_ff <= stq_pkg::TIME_BITS'(req_data.now_ticks)
                    + stq_pkg::TIME_BITS'(req_data.sleep_ticks);
      end
      times_ff <= times_in;
      ids_ff   <= ids_in;
      rsp_ff   <= rsp_in;
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

### rtl/core/sorted_timeout_queue.sv
// Sorted timeout queue: holds up to sixteen sleeping tasks ordered by wake time.
// The request channel (req_valid, req_stall, req_data) carries one item per transfer:
// an insert stores a task id with wake time now plus sleep time, behind any entry
// with an equal or earlier wake time; a poll removes the head entry if its wake
// time is at or before now and returns its id.
// Every item yields exactly one response transfer on rsp_valid, rsp_stall, rsp_data,
// giving the woken task, the dropped flag for an insert into a full queue and the
// number of tasks left waiting.
// Each item first has its request and wake-time sum registered; then all entries are
// compared in parallel, the queue shifts and the response is registered. A new item
// is taken only after the previous item's compare-and-shift step, which waits while the
// response side stalls.
// The response is held in an output register; a new item is accepted while it
// waits, but that item's work waits until the response has been transferred.
// A synchronous reset empties the queue and drops any pending response; the entry
// contents are not cleared.
`include "sorted_timeout_queue_defines.svh"

module sorted_timeout_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data
);

   stq_pkg::cmd_type cmd;
   stq_pkg::sts_type sts;

   stq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   stq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `STQ_ASSERT_ALWAYS(a_exec_needs_room, !cmd.exec || sts.out_free)
   `STQ_ASSERT_ALWAYS(a_load_exec_apart, !(cmd.load && cmd.exec))
   `STQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `STQ_ASSERT_NEXT(a_exec_gives_rsp, cmd.exec, rsp_valid)
   `STQ_ASSERT_ALWAYS(a_pending_bound,
      !rsp_valid || (rsp_data.pending <= 5'(stq_pkg::QUEUE_DEPTH)))

endmodule
